// ----- rtl/ppf_pkg.sv -----
// Package with opcodes, the queued command record and the R3G3B2 packing.
package ppf_pkg;

  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 256;
  localparam int ADDR_MAX_W       = 20;

  localparam logic [2:0] OP_PLOT   = 3'd0;
  localparam logic [2:0] OP_VBLANK = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_SETACT = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_PHOSPHOR = 2'd2;
  localparam logic [1:0] MODE_BAD      = 2'd3;

  localparam logic [7:0] FADE_NUM  = 8'd217;
  localparam logic [7:0] TRAIL_NUM = 8'd250;

  typedef struct packed {
    logic [2:0]            op;
    logic                  in_frame;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            packed_color;
    logic [23:0]           rgb;
    logic                  lit;
    logic                  beam_ok;
    logic [9:0]            beam;
    logic                  act;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pixel_packed;
    logic [7:0]  last_plot_packed;
    logic [31:0] lit_count;
    logic [31:0] dot_count;
    logic        field_busy;
  } res_t;

  function automatic logic [2:0] div255(input logic [10:0] x);
    logic [11:0] s;
    s = 12'(x) + 12'(x[10:8]) + 12'd1;
    return s[10:8];
  endfunction

  function automatic logic [7:0] pack332(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [2:0] rq, gq, bq;
    rq = div255(11'(r) * 11'd7 + 11'd127);
    gq = div255(11'(g) * 11'd7 + 11'd127);
    bq = div255(11'(b) * 11'd3 + 11'd127);
    return {rq, gq, bq[1:0]};
  endfunction

endpackage

// ----- rtl/phosphor_persistence_framebuffer.sv -----
// Top level of the phosphor persistence framebuffer.
// Each beat in yields one result beat. Clear, and vblank in normal mode, sweep the frame
// store one pixel a cycle; a display tick in phosphor mode streams the store through its
// single write port. Each result is written into the result queue as the back end
// finishes and can be popped from there. After reset a clearing pass holds full high.
// Up to two commands and two results queue between the front, the back and the ports.
module phosphor_persistence_framebuffer #(
  parameter int FRAME_WIDTH  = ppf_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ppf_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [9:0]  pos_x,
  input  logic [9:0]  pos_y,
  input  logic [7:0]  color_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [10:0] beam_row,
  input  logic        active_value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_packed,
  output logic [7:0]  last_plot_packed,
  output logic [31:0] lit_count,
  output logic [31:0] dot_count,
  output logic        field_busy
);

  logic [1:0]    draw_mode;
  logic          cmd_valid, cmd_take, init;
  ppf_pkg::cmd_t cmd;
  ppf_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode <= ppf_pkg::MODE_NORMAL;
    end else if (cfg_we && cfg_wdata != ppf_pkg::MODE_BAD) begin
      draw_mode <= cfg_wdata;
    end
  end

  ppf_front #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
    .clk, .rst, .push, .full, .opcode, .pos_x, .pos_y, .color_index, .red, .green, .blue,
    .beam_row, .active_value, .hold(init), .cmd_valid, .cmd_take, .cmd
  );

  ppf_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
    .clk, .rst, .draw_mode, .cmd_valid, .cmd_take, .cmd, .init, .empty, .pop, .res
  );

  assign pixel_packed     = res.pixel_packed;
  assign last_plot_packed = res.last_plot_packed;
  assign lit_count        = res.lit_count;
  assign dot_count        = res.dot_count;
  assign field_busy       = res.field_busy;

`ifndef SYNTHESIS
  a_init_full: assert property (@(posedge clk) init |-> full)
    else $error("input accepted during the clearing pass");
  a_reset_init: assert property (@(posedge clk) $past(rst) && !rst |-> init && empty)
    else $error("clearing pass did not start after reset");
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    draw_mode != ppf_pkg::MODE_BAD)
    else $error("render mode holds an illegal value");
`endif

endmodule

// ----- rtl/ppf_front.sv -----
// Front end: accepts items, decodes them into commands and queues them.
module ppf_front #(
  parameter int FRAME_WIDTH  = ppf_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ppf_pkg::FRAME_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    opcode,
  input  logic [9:0]    pos_x,
  input  logic [9:0]    pos_y,
  input  logic [7:0]    color_index,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic [10:0]   beam_row,
  input  logic          active_value,
  input  logic          hold,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output ppf_pkg::cmd_t cmd
);

  ppf_pkg::cmd_t q [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  ppf_pkg::cmd_t c;
  logic          acc;

  assign full      = (cnt == 2'd2) || hold;
  assign acc       = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_comb begin
    c.op           = opcode;
    c.in_frame     = (11'(pos_x) < 11'(FRAME_WIDTH)) && (11'(pos_y) < 11'(FRAME_HEIGHT));
    c.addr         = ppf_pkg::ADDR_MAX_W'(pos_y) * ppf_pkg::ADDR_MAX_W'(FRAME_WIDTH)
                     + ppf_pkg::ADDR_MAX_W'(pos_x);
    c.packed_color = ppf_pkg::pack332(red, green, blue);
    c.rgb          = {red, green, blue};
    c.lit          = (color_index[5:0] != 6'd0);
    c.beam_ok      = !beam_row[10] && (beam_row < 11'(FRAME_HEIGHT));
    c.beam         = beam_row[9:0];
    c.act          = active_value;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wp] <= c;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) begin
        wp <= !wp;
      end
      if (cmd_take) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(acc) - 2'(cmd_take);
    end
  end

endmodule

// ----- rtl/ppf_back.sv -----
// Back end: executes commands against the frame store and queues results.
module ppf_back #(
  parameter int FRAME_WIDTH  = ppf_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ppf_pkg::FRAME_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    draw_mode,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  ppf_pkg::cmd_t cmd,
  output logic          init,
  output logic          empty,
  input  logic          pop,
  output ppf_pkg::res_t res
);

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int CW  = $clog2(FRAME_WIDTH);
  localparam int RW  = $clog2(FRAME_HEIGHT);
  localparam logic [AW-1:0] LAST = AW'(PIX - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_CLR, S_FADE, S_DRAIN, S_DONE} state_t;
  typedef enum logic [1:0] {F_KEEP, F_TRAIL, F_FADE} fac_t;

  state_t        state;
  logic [23:0]   mem [PIX];
  logic [23:0]   rdata;
  logic [AW-1:0] ra, wa, cnt, wad;
  logic [23:0]   wd;
  logic          we, vld_d;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  fac_t          fac, fac_d;
  logic          split;
  logic [9:0]    beam_q;
  logic          read_in;
  logic [7:0]    pix, last_c;
  logic [31:0]   lit_c, dot_c;
  logic          field;
  ppf_pkg::res_t oq [2];
  logic          owp, orp;
  logic [1:0]    ocnt;
  logic          opush;

  function automatic logic [7:0] scale(input logic [7:0] v, input fac_t f);
    logic [15:0] p;
    p = 16'(v) * 16'((f == F_TRAIL) ? ppf_pkg::TRAIL_NUM : ppf_pkg::FADE_NUM);
    return (f == F_KEEP) ? v : p[15:8];
  endfunction

  assign init     = (state == S_INIT);
  assign cmd_take = (state == S_IDLE) && cmd_valid && (ocnt != 2'd2);
  assign opush    = (state == S_DONE);
  assign empty    = (ocnt == 2'd0);
  assign res      = oq[orp];

  always_comb begin
    if (!split) begin
      fac = F_FADE;
    end else if (10'(row) < beam_q) begin
      fac = F_TRAIL;
    end else if (10'(row) == beam_q) begin
      fac = F_KEEP;
    end else begin
      fac = F_FADE;
    end
  end

  always_comb begin
    ra = (state == S_FADE) ? cnt : cmd.addr[AW-1:0];
    we = 1'b0;
    wa = cnt;
    wd = 24'd0;
    if (vld_d) begin
      we = 1'b1;
      wa = wad;
      wd = {scale(rdata[23:16], fac_d), scale(rdata[15:8], fac_d), scale(rdata[7:0], fac_d)};
    end else if (state == S_INIT || state == S_CLR) begin
      we = 1'b1;
    end else if (cmd_take && cmd.op == ppf_pkg::OP_PLOT && cmd.in_frame) begin
      we = 1'b1;
      wa = cmd.addr[AW-1:0];
      wd = cmd.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
    if (opush) begin
      oq[owp] <= '{pix, last_c, lit_c, dot_c, field};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      cnt    <= '0;
      vld_d  <= 1'b0;
      last_c <= 8'd0;
      lit_c  <= 32'd0;
      dot_c  <= 32'd0;
      field  <= 1'b0;
      owp    <= 1'b0;
      orp    <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      vld_d <= (state == S_FADE);
      if (opush) begin
        owp <= !owp;
      end
      if (pop && !empty) begin
        orp <= !orp;
      end
      ocnt <= ocnt + 2'(opush) - 2'(pop && !empty);
      case (state)
        S_INIT, S_CLR: begin
          cnt <= (cnt == LAST) ? '0 : cnt + AW'(1);
          if (cnt == LAST) begin
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (cmd_take) begin
            pix     <= 8'd0;
            read_in <= cmd.in_frame;
            case (cmd.op)
              ppf_pkg::OP_PLOT: begin
                if (cmd.in_frame) begin
                  dot_c  <= dot_c + 32'd1;
                  lit_c  <= lit_c + 32'(cmd.lit);
                  last_c <= cmd.packed_color;
                  field  <= 1'b1;
                end
                state <= S_DONE;
              end
              ppf_pkg::OP_VBLANK: begin
                field <= 1'b0;
                if (draw_mode == ppf_pkg::MODE_NORMAL) begin
                  lit_c <= 32'd0;
                  cnt   <= '0;
                  state <= S_CLR;
                end else begin
                  state <= S_DONE;
                end
              end
              ppf_pkg::OP_TICK: begin
                if (draw_mode == ppf_pkg::MODE_PHOSPHOR) begin
                  split  <= field && cmd.beam_ok;
                  beam_q <= cmd.beam;
                  cnt    <= '0;
                  row    <= '0;
                  col    <= '0;
                  state  <= S_FADE;
                end else begin
                  state <= S_DONE;
                end
              end
              ppf_pkg::OP_CLEAR: begin
                lit_c <= 32'd0;
                cnt   <= '0;
                state <= S_CLR;
              end
              ppf_pkg::OP_SETACT: begin
                field <= cmd.act;
                state <= S_DONE;
              end
              ppf_pkg::OP_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          pix   <= read_in ? ppf_pkg::pack332(rdata[23:16], rdata[15:8], rdata[7:0]) : 8'd0;
          state <= S_DONE;
        end
        S_FADE: begin
          wad   <= cnt;
          fac_d <= fac;
          cnt   <= cnt + AW'(1);
          if (col == COL_LAST) begin
            col <= '0;
            row <= row + RW'(1);
          end else begin
            col <= col + CW'(1);
          end
          if (cnt == LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the phosphor persistence framebuffer: directed, then random.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [2:0]  op;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [10:0] beam;
    logic        act;
  } beat_t;

  typedef struct {
    int            cfg;
    beat_t         bt;
    bit            known;
    ppf_pkg::res_t res;
  } dir_row_t;

  localparam int W = ppf_pkg::FRAME_WIDTH_DEF;
  localparam int H = ppf_pkg::FRAME_HEIGHT_DEF;
  localparam int N_DIR = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic push = 1'b0;
  logic full;
  logic [2:0] opcode = '0;
  logic [9:0] pos_x = '0;
  logic [9:0] pos_y = '0;
  logic [7:0] color_index = '0;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic [10:0] beam_row = '0;
  logic active_value = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] pixel_packed;
  logic [7:0] last_plot_packed;
  logic [31:0] lit_count;
  logic [31:0] dot_count;
  logic field_busy;

  logic [23:0] pix_mem [0:W*H-1];
  logic        fld_flag;
  logic [31:0] lit_cnt;
  logic [31:0] dot_cnt;
  logic [7:0]  last_pk;
  logic [1:0]  mode;

  ppf_pkg::res_t results_due[$];
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cnt = 0;
  int errors = 0;
  int n_beats = 0;
  int n_results = 0;
  int n_sweeps = 0;
  dir_row_t dir_tab [N_DIR];

  phosphor_persistence_framebuffer uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y),
    .color_index(color_index), .red(red), .green(green), .blue(blue),
    .beam_row(beam_row), .active_value(active_value), .empty(empty), .pop(pop),
    .pixel_packed(pixel_packed), .last_plot_packed(last_plot_packed),
    .lit_count(lit_count), .dot_count(dot_count), .field_busy(field_busy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] to_r3g3b2(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    int unsigned rq, gq, bq;
    rq = (r * 7 + 127) / 255;
    gq = (g * 7 + 127) / 255;
    bq = (b * 3 + 127) / 255;
    return 8'((rq << 5) | (gq << 2) | bq);
  endfunction

  function automatic logic [23:0] dim_pixel(input logic [23:0] p, input int unsigned num);
    logic [23:0] q;
    for (int c = 0; c < 3; c++) q[c*8 +: 8] = 8'((p[c*8 +: 8] * num) / 256);
    return q;
  endfunction

  function automatic bit sweeps(input logic [2:0] op);
    return op == ppf_pkg::OP_CLEAR ||
           (op == ppf_pkg::OP_VBLANK && mode == ppf_pkg::MODE_NORMAL) ||
           (op == ppf_pkg::OP_TICK && mode == ppf_pkg::MODE_PHOSPHOR);
  endfunction

  function automatic void blank_frame();
    for (int i = 0; i < W*H; i++) pix_mem[i] = '0;
    lit_cnt = '0;
  endfunction

  function automatic ppf_pkg::res_t frame_step(input beat_t bt);
    ppf_pkg::res_t o;
    bit in_frame;
    int addr;
    int beam;
    int unsigned num;
    in_frame = bt.x < W && bt.y < H;
    addr = in_frame ? bt.y * W + bt.x : 0;
    beam = int'($signed(bt.beam));
    o.pixel_packed = '0;
    if (sweeps(bt.op)) n_sweeps++;
    case (bt.op)
      ppf_pkg::OP_PLOT: if (in_frame) begin
        dot_cnt++;
        last_pk = to_r3g3b2(bt.r, bt.g, bt.b);
        if (bt.idx[5:0] != 0) lit_cnt++;
        fld_flag = 1'b1;
        pix_mem[addr] = {bt.r, bt.g, bt.b};
      end
      ppf_pkg::OP_VBLANK: begin
        fld_flag = 1'b0;
        if (mode == ppf_pkg::MODE_NORMAL) blank_frame();
      end
      ppf_pkg::OP_TICK: if (mode == ppf_pkg::MODE_PHOSPHOR) begin
        for (int yy = 0; yy < H; yy++) begin
          if (fld_flag && beam >= 0 && beam < H)
            num = yy < beam ? 250 : (yy > beam ? 217 : 256);
          else
            num = 217;
          if (num != 256)
            for (int xx = 0; xx < W; xx++)
              pix_mem[yy*W + xx] = dim_pixel(pix_mem[yy*W + xx], num);
        end
      end
      ppf_pkg::OP_CLEAR: blank_frame();
      ppf_pkg::OP_SETACT: fld_flag = bt.act;
      ppf_pkg::OP_READ: if (in_frame)
        o.pixel_packed = to_r3g3b2(pix_mem[addr][23:16], pix_mem[addr][15:8],
                                   pix_mem[addr][7:0]);
      default: ;
    endcase
    o.last_plot_packed = last_pk;
    o.lit_count = lit_cnt;
    o.dot_count = dot_cnt;
    o.field_busy = fld_flag;
    return o;
  endfunction

  function automatic beat_t mk(input logic [2:0] op, input int x, input int y, input int idx,
                               input int r, input int g, input int b, input int beam,
                               input int act);
    beat_t bt;
    bt.op = op; bt.x = 10'(x); bt.y = 10'(y); bt.idx = 8'(idx);
    bt.r = 8'(r); bt.g = 8'(g); bt.b = 8'(b); bt.beam = 11'(beam); bt.act = 1'(act);
    return bt;
  endfunction

  task automatic send_beat(input beat_t bt, input bit known, input ppf_pkg::res_t known_res);
    ppf_pkg::res_t pred;
    do begin
      @(negedge clk);
      if (hold_cnt == 0 && $urandom_range(0, 99) < send_idle) begin
        push = 1'b0;
      end else begin
        push = 1'b1;
        opcode = bt.op; pos_x = bt.x; pos_y = bt.y; color_index = bt.idx;
        red = bt.r; green = bt.g; blue = bt.b; beam_row = bt.beam;
        active_value = bt.act;
      end
      @(posedge clk);
    end while (!(push && !full));
    pred = frame_step(bt);
    results_due.push_back(known ? known_res : pred);
    n_beats++;
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (val <= ppf_pkg::MODE_PHOSPHOR) mode = val;
  endtask

  task automatic random_beats(input int count, input int sweep_budget);
    beat_t bt;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) bt.op = ppf_pkg::OP_PLOT;
      else if (pick < 72) bt.op = ppf_pkg::OP_READ;
      else if (pick < 78) bt.op = ppf_pkg::OP_SETACT;
      else if (pick < 84) bt.op = ppf_pkg::OP_VBLANK;
      else if (pick < 91) bt.op = ppf_pkg::OP_TICK;
      else if (pick < 94) bt.op = ppf_pkg::OP_CLEAR;
      else bt.op = 3'($urandom_range(6, 7));
      if (sweeps(bt.op)) begin
        if (sweep_budget == 0) bt.op = ppf_pkg::OP_READ;
        else sweep_budget--;
      end
      if ($urandom_range(0, 99) < 80) begin
        bt.x = 10'($urandom_range(0, 15));
        bt.y = 10'($urandom_range(0, 15));
      end else begin
        bt.x = 10'($urandom);
        bt.y = 10'($urandom);
      end
      bt.idx = 8'($urandom); bt.r = 8'($urandom); bt.g = 8'($urandom); bt.b = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) bt.beam = 11'($urandom_range(0, 20));
      else if (pick < 60) bt.beam = '1;
      else bt.beam = 11'($urandom);
      bt.act = 1'($urandom);
      send_beat(bt, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    ppf_pkg::res_t got, want;
    if (!rst && pop && !empty) begin
      got = '{pixel_packed, last_plot_packed, lit_count, dot_count, field_busy};
      n_results++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = results_due.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("result %0d mismatch: expected %p, got %p",
                                     n_results, want, got);
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        pop = 1'b0;
        hold_cnt--;
      end else begin
        pop = $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  initial begin
    dir_tab[0]  = '{-1, mk(ppf_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0}};
    dir_tab[1]  = '{-1, mk(ppf_pkg::OP_PLOT, 255, 255, 0, 255, 255, 255, 0, 0), 1,
                    '{0, 8'hff, 0, 1, 1}};
    dir_tab[2]  = '{-1, mk(ppf_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 0, 0), 1,
                    '{8'hff, 8'hff, 0, 1, 1}};
    dir_tab[3]  = '{-1, mk(ppf_pkg::OP_PLOT, 256, 0, 1, 9, 9, 9, 0, 0), 0, '0};
    dir_tab[4]  = '{-1, mk(ppf_pkg::OP_PLOT, 0, 1023, 1, 9, 9, 9, 0, 0), 0, '0};
    dir_tab[5]  = '{-1, mk(ppf_pkg::OP_PLOT, 0, 0, 63, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[6]  = '{-1, mk(ppf_pkg::OP_PLOT, 1, 0, 64, 255, 0, 128, 0, 0), 0, '0};
    dir_tab[7]  = '{-1, mk(ppf_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[8]  = '{-1, mk(ppf_pkg::OP_READ, 1023, 1023, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[9]  = '{-1, mk(ppf_pkg::OP_SETACT, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[10] = '{-1, mk(ppf_pkg::OP_SETACT, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0};
    dir_tab[11] = '{-1, mk(3'd6, 3, 3, 255, 1, 2, 3, 0, 1), 0, '0};
    dir_tab[12] = '{-1, mk(3'd7, 3, 3, 255, 1, 2, 3, 0, 0), 0, '0};
    dir_tab[13] = '{-1, mk(ppf_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 5, 0), 0, '0};
    dir_tab[14] = '{-1, mk(ppf_pkg::OP_VBLANK, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[15] = '{-1, mk(ppf_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[16] = '{2, mk(ppf_pkg::OP_PLOT, 5, 5, 1, 200, 100, 50, 0, 0), 0, '0};
    dir_tab[17] = '{-1, mk(ppf_pkg::OP_PLOT, 5, 6, 2, 255, 255, 255, 0, 0), 0, '0};
    dir_tab[18] = '{-1, mk(ppf_pkg::OP_PLOT, 5, 4, 3, 255, 255, 255, 0, 0), 0, '0};
    dir_tab[19] = '{-1, mk(ppf_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 5, 0), 0, '0};
    dir_tab[20] = '{-1, mk(ppf_pkg::OP_READ, 5, 4, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[21] = '{-1, mk(ppf_pkg::OP_READ, 5, 6, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[22] = '{-1, mk(ppf_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, -1, 0), 0, '0};
    dir_tab[23] = '{-1, mk(ppf_pkg::OP_READ, 5, 5, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[24] = '{-1, mk(ppf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0};
    dir_tab[25] = '{1, mk(ppf_pkg::OP_PLOT, 7, 7, 5, 60, 70, 80, 0, 0), 0, '0};
    dir_tab[26] = '{-1, mk(ppf_pkg::OP_VBLANK, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0};

    for (int i = 0; i < W*H; i++) pix_mem[i] = '0;
    fld_flag = 1'b0; lit_cnt = '0; dot_cnt = '0; last_pk = '0; mode = ppf_pkg::MODE_NORMAL;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].cfg >= 0) write_mode(2'(dir_tab[i].cfg));
      send_beat(dir_tab[i].bt, dir_tab[i].known, dir_tab[i].res);
    end
    send_beat(mk(ppf_pkg::OP_READ, 7, 7, 0, 0, 0, 0, 0, 0), 1'b0, '0);

    send_idle = 0; recv_idle = 0; hold_cnt = 300;
    random_beats(100, 2);
    write_mode(ppf_pkg::MODE_PHOSPHOR);
    send_idle = 76; recv_idle = 0;
    random_beats(100, 3);
    write_mode(ppf_pkg::MODE_BAD);
    send_idle = 0; recv_idle = 76;
    random_beats(100, 2);
    write_mode(ppf_pkg::MODE_NORMAL);
    send_idle = 38; recv_idle = 38;
    random_beats(100, 2);

    drain();
    $display("Sent %0d beats (%0d full-frame sweeps) over four handshake phases;",
             n_beats, n_sweeps);
    $display("render modes normal, persist, phosphor and a rejected write; %0d results checked.",
             n_results);
    if (errors == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, results_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
